FILE: hdl/fmb_pkg.sv
// ----------------------------------------------------------------------------
// fmb_pkg: shared types and constants of the UDP/IPv4 frame builder
// Field widths, header constants, register indexes and the command word that
// travels from the front end to the byte emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package fmb_pkg;

  // Field widths
  localparam int LEN_W      = 11;
  localparam int BYTE_W     = 8;
  localparam int MAC_W      = 48;
  localparam int IP_W       = 32;
  localparam int PORT_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // Default payload limit
  localparam int MAX_PAYLOAD_DEF = 1476;

  // Header layout
  localparam int HDR_BYTES = 42;
  localparam int HDR_IDX_W = $clog2(HDR_BYTES);
  localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = HDR_IDX_W'(HDR_BYTES - 1);

  // Header constants
  localparam logic [7:0]  ETH_TYPE_HI    = 8'h08;
  localparam logic [7:0]  IP_VER_IHL     = 8'h45;
  localparam logic [7:0]  IP_TTL         = 8'd5;
  localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
  localparam logic [15:0] IP_WORD0       = {IP_VER_IHL, 8'h00};
  localparam logic [15:0] IP_WORD_TTL    = {IP_TTL, IP_PROTO_UDP};
  localparam logic [15:0] IP_UDP_OVERHD  = 16'd28;
  localparam logic [15:0] UDP_HDR_LEN    = 16'd8;
  localparam logic [7:0]  SRC_PORT_OFFS  = 8'd100;

  // Checksum accumulator: nine 16-bit words fit in 20 bits
  localparam int CSUM_ACC_W = 20;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEST_MAC = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_MAC  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_IP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_IP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DST_PORT = 3'd4;

  // Input action codes
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_PAYLOAD = 1'b1;

  // Command kinds
  typedef logic [1:0] cmd_kind_t;
  localparam cmd_kind_t CMD_ERR  = 2'd0;
  localparam cmd_kind_t CMD_HDR  = 2'd1;
  localparam cmd_kind_t CMD_DATA = 2'd2;

  // Command queue depth
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [LEN_W-1:0]   len;
    logic [BYTE_W-1:0]  data;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic [MAC_W-1:0]  dest_mac;
    logic [MAC_W-1:0]  src_mac;
    logic [IP_W-1:0]   src_ip;
    logic [IP_W-1:0]   dst_ip;
    logic [PORT_W-1:0] dst_port;
  } cfg_regs_t;

endpackage

`default_nettype wire

FILE: hdl/fmb_in_if.sv
// ----------------------------------------------------------------------------
// fmb_in_if: input item channel
// Start and payload items with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface fmb_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [fmb_pkg::LEN_W-1:0]   payload_length;
  logic [fmb_pkg::BYTE_W-1:0]  data_byte;

  modport source (output valid, action, payload_length, data_byte, input ready);
  modport sink   (input valid, action, payload_length, data_byte, output ready);
endinterface

`default_nettype wire

FILE: hdl/fmb_out_if.sv
// ----------------------------------------------------------------------------
// fmb_out_if: frame byte channel
// One frame byte per transaction, with last and error flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface fmb_out_if;
  logic                        valid;
  logic                        ready;
  logic [fmb_pkg::BYTE_W-1:0]  frame_byte;
  logic                        last;
  logic                        error;

  modport source (output valid, frame_byte, last, error, input ready);
  modport sink   (input valid, frame_byte, last, error, output ready);
endinterface

`default_nettype wire

FILE: hdl/fmb_cfg_if.sv
// ----------------------------------------------------------------------------
// fmb_cfg_if: configuration write channel
// Register index and write data with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface fmb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fmb_pkg::CFG_IDX_W-1:0]   index;
  logic [fmb_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/fmb_cfg.sv
// ----------------------------------------------------------------------------
// fmb_cfg: configuration register file
// Holds MAC, IP and port settings; indexes beyond the list are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module fmb_cfg (
  input  wire                 clk,
  input  wire                 rst,
  fmb_cfg_if.sink             cfg,
  output fmb_pkg::cfg_regs_t  regs
);

  fmb_pkg::cfg_regs_t regs_q;
  logic               wr;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid && cfg.ready;
  assign regs      = regs_q;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs_q <= '0;
    end else if (wr) begin
      unique case (cfg.index)
        fmb_pkg::REG_DEST_MAC: regs_q.dest_mac <= cfg.data[fmb_pkg::MAC_W-1:0];
        fmb_pkg::REG_SRC_MAC:  regs_q.src_mac  <= cfg.data[fmb_pkg::MAC_W-1:0];
        fmb_pkg::REG_SRC_IP:   regs_q.src_ip   <= cfg.data[fmb_pkg::IP_W-1:0];
        fmb_pkg::REG_DST_IP:   regs_q.dst_ip   <= cfg.data[fmb_pkg::IP_W-1:0];
        fmb_pkg::REG_DST_PORT: regs_q.dst_port <= cfg.data[fmb_pkg::PORT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/fmb_front.sv
// ----------------------------------------------------------------------------
// fmb_front: item classifier
// Accepts input items, checks them against the open frame and turns each
// into one command: header burst, payload byte or error.
// ----------------------------------------------------------------------------
`default_nettype none

module fmb_front #(
  parameter int MAX_PAYLOAD = fmb_pkg::MAX_PAYLOAD_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  fmb_in_if.sink              item,
  input  wire                 queue_full,
  output logic                push,
  output fmb_pkg::cmd_t       push_cmd
);

  localparam logic [fmb_pkg::LEN_W-1:0] MaxLen = fmb_pkg::LEN_W'(MAX_PAYLOAD);

  logic [fmb_pkg::LEN_W-1:0] bytes_remaining;
  logic [fmb_pkg::LEN_W-1:0] bytes_remaining_next;

  assign item.ready = !queue_full;
  assign push       = item.valid && item.ready;

  // Classify the item
  always_comb begin
    push_cmd             = '0;
    bytes_remaining_next = bytes_remaining;
    push_cmd.kind        = fmb_pkg::CMD_ERR;
    if (item.action == fmb_pkg::ACT_PAYLOAD) begin
      if (bytes_remaining != '0) begin
        push_cmd.kind        = fmb_pkg::CMD_DATA;
        push_cmd.data        = item.data_byte;
        push_cmd.last        = (bytes_remaining == fmb_pkg::LEN_W'(1));
        bytes_remaining_next = bytes_remaining - fmb_pkg::LEN_W'(1);
      end
    end else begin
      if (item.payload_length != '0 && item.payload_length <= MaxLen) begin
        push_cmd.kind        = fmb_pkg::CMD_HDR;
        push_cmd.len         = item.payload_length;
        bytes_remaining_next = item.payload_length;
      end
    end
  end

  // Open frame tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
    end else if (push) begin
      bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/fmb_queue.sv
// ----------------------------------------------------------------------------
// fmb_queue: command queue
// Short FIFO between the classifier and the byte emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module fmb_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  wire fmb_pkg::cmd_t  push_cmd,
  output logic                full,
  input  wire                 pop,
  output fmb_pkg::cmd_t       head,
  output logic                empty
);

  localparam int PtrW = $clog2(fmb_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(fmb_pkg::QUEUE_DEPTH + 1);

  fmb_pkg::cmd_t   entries [fmb_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full  = (count == CntW'(fmb_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(fmb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(fmb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/fmb_back.sv
// ----------------------------------------------------------------------------
// fmb_back: byte emitter
// Carries out queued commands: a header burst of 42 bytes with the IPv4
// checksum accumulated on the way, a payload byte, or an error result.
// ----------------------------------------------------------------------------
`default_nettype none

module fmb_back (
  input  wire                      clk,
  input  wire                      rst,
  input  wire fmb_pkg::cfg_regs_t  regs,
  input  wire fmb_pkg::cmd_t       head,
  input  wire                      empty,
  output logic                     pop,
  fmb_out_if.source                result
);

  localparam int AccW = fmb_pkg::CSUM_ACC_W;

  logic [fmb_pkg::HDR_IDX_W-1:0] idx;
  logic [AccW-1:0]               acc;
  logic [AccW-1:0]               acc_next;
  logic                          out_valid;
  logic [7:0]                    out_byte;
  logic                          out_last;
  logic                          out_error;
  logic                          advance;
  logic                          fire;
  logic                          is_hdr;
  logic [15:0]                   ip_len;
  logic [15:0]                   udp_len;
  logic [15:0]                   csum;
  logic [15:0]                   csum_word;
  logic [7:0]                    port_hi;
  logic [7:0]                    port_lo;
  logic [7:0]                    hdr_byte;

  assign advance = !out_valid || result.ready;
  assign fire    = advance && !empty;
  assign is_hdr  = (head.kind == fmb_pkg::CMD_HDR);
  assign pop     = fire && (!is_hdr || idx == fmb_pkg::HDR_LAST_IDX);

  assign ip_len  = fmb_pkg::IP_UDP_OVERHD + 16'(head.len);
  assign udp_len = fmb_pkg::UDP_HDR_LEN + 16'(head.len);
  assign csum    = ~acc[15:0];
  assign port_hi = regs.dst_port[15:8];
  assign port_lo = regs.dst_port[7:0];

  // Checksum word for the current header step
  always_comb begin
    unique case (idx)
      fmb_pkg::HDR_IDX_W'(0): csum_word = fmb_pkg::IP_WORD0;
      fmb_pkg::HDR_IDX_W'(1): csum_word = ip_len;
      fmb_pkg::HDR_IDX_W'(4): csum_word = fmb_pkg::IP_WORD_TTL;
      fmb_pkg::HDR_IDX_W'(5): csum_word = regs.src_ip[31:16];
      fmb_pkg::HDR_IDX_W'(6): csum_word = regs.src_ip[15:0];
      fmb_pkg::HDR_IDX_W'(7): csum_word = regs.dst_ip[31:16];
      fmb_pkg::HDR_IDX_W'(8): csum_word = regs.dst_ip[15:0];
      default:                csum_word = 16'h0000;
    endcase
  end

  // Accumulate words during the first header steps, then fold carries twice
  always_comb begin
    acc_next = acc;
    if (idx == '0) begin
      acc_next = AccW'(csum_word);
    end else if (idx < fmb_pkg::HDR_IDX_W'(9)) begin
      acc_next = acc + AccW'(csum_word);
    end else if (idx < fmb_pkg::HDR_IDX_W'(11)) begin
      acc_next = AccW'(acc[15:0]) + AccW'(acc[AccW-1:16]);
    end
  end

  // Header byte in wire order
  always_comb begin
    unique case (idx)
      fmb_pkg::HDR_IDX_W'(0):  hdr_byte = regs.dest_mac[47:40];
      fmb_pkg::HDR_IDX_W'(1):  hdr_byte = regs.dest_mac[39:32];
      fmb_pkg::HDR_IDX_W'(2):  hdr_byte = regs.dest_mac[31:24];
      fmb_pkg::HDR_IDX_W'(3):  hdr_byte = regs.dest_mac[23:16];
      fmb_pkg::HDR_IDX_W'(4):  hdr_byte = regs.dest_mac[15:8];
      fmb_pkg::HDR_IDX_W'(5):  hdr_byte = regs.dest_mac[7:0];
      fmb_pkg::HDR_IDX_W'(6):  hdr_byte = regs.src_mac[47:40];
      fmb_pkg::HDR_IDX_W'(7):  hdr_byte = regs.src_mac[39:32];
      fmb_pkg::HDR_IDX_W'(8):  hdr_byte = regs.src_mac[31:24];
      fmb_pkg::HDR_IDX_W'(9):  hdr_byte = regs.src_mac[23:16];
      fmb_pkg::HDR_IDX_W'(10): hdr_byte = regs.src_mac[15:8];
      fmb_pkg::HDR_IDX_W'(11): hdr_byte = regs.src_mac[7:0];
      fmb_pkg::HDR_IDX_W'(12): hdr_byte = fmb_pkg::ETH_TYPE_HI;
      fmb_pkg::HDR_IDX_W'(14): hdr_byte = fmb_pkg::IP_VER_IHL;
      fmb_pkg::HDR_IDX_W'(16): hdr_byte = ip_len[15:8];
      fmb_pkg::HDR_IDX_W'(17): hdr_byte = ip_len[7:0];
      fmb_pkg::HDR_IDX_W'(22): hdr_byte = fmb_pkg::IP_TTL;
      fmb_pkg::HDR_IDX_W'(23): hdr_byte = fmb_pkg::IP_PROTO_UDP;
      fmb_pkg::HDR_IDX_W'(24): hdr_byte = csum[15:8];
      fmb_pkg::HDR_IDX_W'(25): hdr_byte = csum[7:0];
      fmb_pkg::HDR_IDX_W'(26): hdr_byte = regs.src_ip[31:24];
      fmb_pkg::HDR_IDX_W'(27): hdr_byte = regs.src_ip[23:16];
      fmb_pkg::HDR_IDX_W'(28): hdr_byte = regs.src_ip[15:8];
      fmb_pkg::HDR_IDX_W'(29): hdr_byte = regs.src_ip[7:0];
      fmb_pkg::HDR_IDX_W'(30): hdr_byte = regs.dst_ip[31:24];
      fmb_pkg::HDR_IDX_W'(31): hdr_byte = regs.dst_ip[23:16];
      fmb_pkg::HDR_IDX_W'(32): hdr_byte = regs.dst_ip[15:8];
      fmb_pkg::HDR_IDX_W'(33): hdr_byte = regs.dst_ip[7:0];
      fmb_pkg::HDR_IDX_W'(34): hdr_byte = port_hi - fmb_pkg::SRC_PORT_OFFS;
      fmb_pkg::HDR_IDX_W'(35): hdr_byte = port_lo;
      fmb_pkg::HDR_IDX_W'(36): hdr_byte = port_hi;
      fmb_pkg::HDR_IDX_W'(37): hdr_byte = port_lo;
      fmb_pkg::HDR_IDX_W'(38): hdr_byte = udp_len[15:8];
      fmb_pkg::HDR_IDX_W'(39): hdr_byte = udp_len[7:0];
      default:                 hdr_byte = 8'h00;
    endcase
  end

  // Header step counter and checksum accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (fire && is_hdr) begin
      idx <= (idx == fmb_pkg::HDR_LAST_IDX) ? '0 : idx + fmb_pkg::HDR_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_hdr) begin
      acc <= acc_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_last  <= 1'b0;
      out_error <= 1'b0;
      out_byte  <= 8'h00;
      case (head.kind)
        fmb_pkg::CMD_HDR: begin
          out_byte <= hdr_byte;
        end
        fmb_pkg::CMD_DATA: begin
          out_byte <= head.data;
          out_last <= head.last;
        end
        default: begin
          out_error <= 1'b1;
        end
      endcase
    end
  end

  assign result.valid      = out_valid;
  assign result.frame_byte = out_byte;
  assign result.last       = out_last;
  assign result.error      = out_error;

endmodule

`default_nettype wire

FILE: hdl/udp_ipv4_frame_builder.sv
// ----------------------------------------------------------------------------
// udp_ipv4_frame_builder: Ethernet II / IPv4 / UDP transmit framer
// Turns start and payload items into a byte stream of framed packets.
// ----------------------------------------------------------------------------
// Usage:
//   item   - input channel. A start transaction (action 0) with a valid length
//            produces the 42 header bytes; each payload transaction (action 1)
//            produces one byte, the final one flagged last. Bad lengths and
//            payload bytes with no open frame give a single error byte.
//   result - one frame byte per transaction, with last and error flags.
//   cfg    - register writes (MAC, IP, port), to be issued only while no
//            transaction is in flight; always ready.
// Path: an accepted item is first written into the command queue, and its first result
//   then passes through the output register before it is on the port.
// Throughput: one payload byte per cycle while the receiver does not stall; a start
//   occupies the emitter for all 42 header bytes, while the two-entry command queue
//   keeps accepting items until it fills.
// Reset: the configuration registers clear to zero, no frame is open and the queue empties.
// When the receiver stalls, the output register holds its byte, the emitter
//   pauses and the queue backs up into item.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module udp_ipv4_frame_builder #(
  parameter int MAX_PAYLOAD = fmb_pkg::MAX_PAYLOAD_DEF
) (
  input  wire        clk,
  input  wire        rst,
  fmb_in_if.sink     item,
  fmb_out_if.source  result,
  fmb_cfg_if.sink    cfg
);

  fmb_pkg::cfg_regs_t regs;
  fmb_pkg::cmd_t      push_cmd;
  fmb_pkg::cmd_t      head;
  logic               push;
  logic               pop;
  logic               full;
  logic               empty;

  fmb_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  fmb_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .queue_full (full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  fmb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  fmb_back u_back (
    .clk    (clk),
    .rst    (rst),
    .regs   (regs),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

`default_nettype wire

FILE: test/tb_udp_ipv4_frame_builder.sv
// ----------------------------------------------------------------------------
// tb_udp_ipv4_frame_builder: self-checking bench for the UDP/IPv4 framer
// A stimulus table covers bad lengths, stray payload bytes, the largest frame,
// restarts while a frame is open and source port wrap. Random frames follow.
// Every frame byte is compared with a byte-level model of the framer or a pinned table value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_udp_ipv4_frame_builder;

  // Header fields as they appear on the wire
  localparam logic [7:0]  ETHERTYPE_HI   = 8'h08;
  localparam logic [7:0]  IPV4_VER_IHL   = 8'h45;
  localparam logic [7:0]  IPV4_TTL       = 8'd5;
  localparam logic [7:0]  IPV4_PROTO_UDP = 8'd17;
  localparam logic [7:0]  SPORT_OFFSET   = 8'd100;
  localparam logic [15:0] IPV4_UDP_HDRS  = 16'd28;
  localparam logic [15:0] UDP_HDR_BYTES  = 16'd8;

  localparam logic [fmb_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam int RANDOM_ITEMS = 388;

  typedef struct packed {
    logic                       action;
    logic [fmb_pkg::LEN_W-1:0]  len;
    logic [fmb_pkg::BYTE_W-1:0] data;
  } frame_in_t;

  typedef struct packed {
    logic [fmb_pkg::BYTE_W-1:0] frame_byte;
    logic                       last;
    logic                       error;
  } frame_out_t;

  typedef enum logic [2:0] {
    PROF_KEEP, PROF_ZERO, PROF_ONES, PROF_WRAP, PROF_RANDOM
  } cfg_profile_t;

  // One stimulus row: optional register profile first, then one transaction
  typedef struct packed {
    cfg_profile_t profile;
    frame_in_t    it;
    logic         pinned;
    frame_out_t   pin;
  } dir_row_t;

  localparam frame_out_t ERR_BYTE = '{8'h00, 1'b0, 1'b1};
  localparam frame_out_t NO_PIN   = '{8'h00, 1'b0, 1'b0};
  localparam int DIR_ROWS = 21;

  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // reset registers: stray byte, bad lengths, a one-byte frame
    '{PROF_KEEP, '{fmb_pkg::ACT_PAYLOAD, 11'h7FF, 8'h5A}, 1'b1, ERR_BYTE},
    '{PROF_KEEP, '{fmb_pkg::ACT_START, 11'd0, 8'hFF}, 1'b1, ERR_BYTE},
    '{PROF_KEEP, '{fmb_pkg::ACT_START, 11'h7FF, 8'h00}, 1'b1, ERR_BYTE},
    '{PROF_KEEP, '{fmb_pkg::ACT_START, 11'(fmb_pkg::MAX_PAYLOAD_DEF + 1), 8'h00},
      1'b1, ERR_BYTE},
    '{PROF_KEEP, '{fmb_pkg::ACT_START, 11'd1, 8'h00}, 1'b0, NO_PIN},
    '{PROF_KEEP, '{fmb_pkg::ACT_PAYLOAD, 11'd0, 8'hFF}, 1'b1, '{8'hFF, 1'b1, 1'b0}},
    '{PROF_KEEP, '{fmb_pkg::ACT_PAYLOAD, 11'd0, 8'h00}, 1'b1, ERR_BYTE},
    // all-ones registers, largest frame, then a restart while it is open
    '{PROF_ONES, '{fmb_pkg::ACT_START, 11'(fmb_pkg::MAX_PAYLOAD_DEF), 8'h00},
      1'b0, NO_PIN},
    '{PROF_KEEP, '{fmb_pkg::ACT_PAYLOAD, 11'd0, 8'h00}, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{PROF_KEEP, '{fmb_pkg::ACT_PAYLOAD, 11'd0, 8'hFF}, 1'b1, '{8'hFF, 1'b0, 1'b0}},
    '{PROF_KEEP, '{fmb_pkg::ACT_START, 11'd3, 8'h00}, 1'b0, NO_PIN},
    '{PROF_KEEP, '{fmb_pkg::ACT_PAYLOAD, 11'd0, 8'h01}, 1'b1, '{8'h01, 1'b0, 1'b0}},
    '{PROF_KEEP, '{fmb_pkg::ACT_PAYLOAD, 11'd0, 8'h80}, 1'b1, '{8'h80, 1'b0, 1'b0}},
    '{PROF_KEEP, '{fmb_pkg::ACT_PAYLOAD, 11'd0, 8'h7F}, 1'b1, '{8'h7F, 1'b1, 1'b0}},
    '{PROF_KEEP, '{fmb_pkg::ACT_PAYLOAD, 11'd0, 8'hC3}, 1'b1, ERR_BYTE},
    // port high byte below the offset: source port wraps
    '{PROF_WRAP, '{fmb_pkg::ACT_START, 11'd2, 8'h00}, 1'b0, NO_PIN},
    '{PROF_KEEP, '{fmb_pkg::ACT_PAYLOAD, 11'd0, 8'h55}, 1'b1, '{8'h55, 1'b0, 1'b0}},
    '{PROF_KEEP, '{fmb_pkg::ACT_PAYLOAD, 11'd0, 8'hAA}, 1'b1, '{8'hAA, 1'b1, 1'b0}},
    '{PROF_KEEP, '{fmb_pkg::ACT_START, 11'd1024, 8'h00}, 1'b0, NO_PIN},
    '{PROF_KEEP, '{fmb_pkg::ACT_START, 11'd1, 8'h00}, 1'b0, NO_PIN},
    '{PROF_KEEP, '{fmb_pkg::ACT_PAYLOAD, 11'd0, 8'h3C}, 1'b1, '{8'h3C, 1'b1, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  fmb_in_if  in_ch ();
  fmb_out_if out_ch ();
  fmb_cfg_if cfg_ch ();

  udp_ipv4_frame_builder dut (
    .clk    (clk),
    .rst    (rst),
    .item   (in_ch),
    .result (out_ch),
    .cfg    (cfg_ch)
  );

  always #1 clk = ~clk;

  // Framer model state
  fmb_pkg::cfg_regs_t        link_cfg = '0;
  logic [fmb_pkg::LEN_W-1:0] open_bytes_left = '0;
  frame_out_t                expected_bytes[$];

  int   fault_count = 0;
  int   items_sent = 0;
  int   burst_left = 0;
  logic gap_free = 1'b0;

  // Bytes that one accepted transaction produces; updates the open frame
  function automatic void predict_frame_bytes(input frame_in_t it, ref frame_out_t outq[$]);
    logic [15:0] ip_len;
    logic [15:0] udp_len;
    logic [15:0] csum;
    logic [19:0] acc;
    logic [7:0]  hdr [fmb_pkg::HDR_BYTES];
    logic [7:0]  port_hi;
    logic [7:0]  port_lo;
    outq = {};
    if (it.action == fmb_pkg::ACT_PAYLOAD) begin
      if (open_bytes_left == '0) begin
        outq.push_back(ERR_BYTE);
      end else begin
        outq.push_back('{it.data, open_bytes_left == 11'd1, 1'b0});
        open_bytes_left = open_bytes_left - 11'd1;
      end
    end else if (it.len == '0 || it.len > 11'(fmb_pkg::MAX_PAYLOAD_DEF)) begin
      outq.push_back(ERR_BYTE);
    end else begin
      ip_len  = IPV4_UDP_HDRS + 16'(it.len);
      udp_len = UDP_HDR_BYTES + 16'(it.len);
      // ones-complement sum of the IPv4 header, checksum word as zero
      acc = 20'({IPV4_VER_IHL, 8'h00}) + 20'(ip_len) + 20'({IPV4_TTL, IPV4_PROTO_UDP})
          + 20'(link_cfg.src_ip[31:16]) + 20'(link_cfg.src_ip[15:0])
          + 20'(link_cfg.dst_ip[31:16]) + 20'(link_cfg.dst_ip[15:0]);
      acc = 20'(acc[15:0]) + 20'(acc[19:16]);
      acc = 20'(acc[15:0]) + 20'(acc[19:16]);
      csum = ~acc[15:0];
      port_hi = link_cfg.dst_port[15:8];
      port_lo = link_cfg.dst_port[7:0];
      for (int i = 0; i < 6; i++) begin
        hdr[i]     = link_cfg.dest_mac[8*(5-i) +: 8];
        hdr[6 + i] = link_cfg.src_mac[8*(5-i) +: 8];
      end
      hdr[12] = ETHERTYPE_HI;   hdr[13] = 8'h00;
      hdr[14] = IPV4_VER_IHL;   hdr[15] = 8'h00;
      hdr[16] = ip_len[15:8];   hdr[17] = ip_len[7:0];
      hdr[18] = 8'h00;          hdr[19] = 8'h00;
      hdr[20] = 8'h00;          hdr[21] = 8'h00;
      hdr[22] = IPV4_TTL;       hdr[23] = IPV4_PROTO_UDP;
      hdr[24] = csum[15:8];     hdr[25] = csum[7:0];
      for (int i = 0; i < 4; i++) begin
        hdr[26 + i] = link_cfg.src_ip[8*(3-i) +: 8];
        hdr[30 + i] = link_cfg.dst_ip[8*(3-i) +: 8];
      end
      hdr[34] = port_hi - SPORT_OFFSET;
      hdr[35] = port_lo;
      hdr[36] = port_hi;        hdr[37] = port_lo;
      hdr[38] = udp_len[15:8];  hdr[39] = udp_len[7:0];
      hdr[40] = 8'h00;          hdr[41] = 8'h00;
      for (int i = 0; i < fmb_pkg::HDR_BYTES; i++) outq.push_back('{hdr[i], 1'b0, 1'b0});
      // a new start drops whatever was left of an open frame
      open_bytes_left = it.len;
    end
  endfunction

  // Send one transaction in bursts with random gaps; queue its bytes on accept
  task automatic push_item(input frame_in_t it, input logic pinned, input frame_out_t pin);
    frame_out_t predicted[$];
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0 || gap_free) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid          <= 1'b1;
    in_ch.action         <= it.action;
    in_ch.payload_length <= it.len;
    in_ch.data_byte      <= it.data;
    do @(posedge clk); while (!in_ch.ready);
    predict_frame_bytes(it, predicted);
    if (pinned) expected_bytes.push_back(pin);
    else foreach (predicted[k]) expected_bytes.push_back(predicted[k]);
    items_sent++;
  endtask

  // Register write; the caller drops valid after the last one
  task automatic write_reg(input logic [fmb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fmb_pkg::CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      fmb_pkg::REG_DEST_MAC: link_cfg.dest_mac = val;
      fmb_pkg::REG_SRC_MAC:  link_cfg.src_mac  = val;
      fmb_pkg::REG_SRC_IP:   link_cfg.src_ip   = val[31:0];
      fmb_pkg::REG_DST_IP:   link_cfg.dst_ip   = val[31:0];
      fmb_pkg::REG_DST_PORT: link_cfg.dst_port = val[15:0];
      default: ;
    endcase
  endtask

  // Stop sending and let every queued byte drain out
  task automatic settle_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Load all registers; narrow ones get junk above their width
  task automatic apply_profile(input cfg_profile_t prof);
    fmb_pkg::cfg_regs_t v;
    case (prof)
      PROF_ZERO: v = '0;
      PROF_ONES: v = '1;
      PROF_WRAP: v = '{48'h0123_4567_89AB, 48'hFEDC_BA98_7654,
                       32'hC0A8_0001, 32'hC0A8_00FE, 16'h1F90};
      default: begin
        v.dest_mac = 48'({$urandom, $urandom});
        v.src_mac  = 48'({$urandom, $urandom});
        v.src_ip   = $urandom;
        v.dst_ip   = $urandom;
        v.dst_port = 16'($urandom);
      end
    endcase
    write_reg(fmb_pkg::REG_DEST_MAC, v.dest_mac);
    write_reg(fmb_pkg::REG_SRC_MAC, v.src_mac);
    write_reg(fmb_pkg::REG_SRC_IP, {16'($urandom), v.src_ip});
    write_reg(fmb_pkg::REG_DST_IP, {16'($urandom), v.dst_ip});
    write_reg(fmb_pkg::REG_DST_PORT, {32'($urandom), v.dst_port});
    write_reg(REG_UNMAPPED, 48'({$urandom, $urandom}));
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic frame_in_t make_item(input logic action, input int len);
    frame_in_t it;
    it.action = action;
    it.len    = (action == fmb_pkg::ACT_START) ? 11'(len) : 11'($urandom);
    it.data   = 8'($urandom);
    return it;
  endfunction

  // Mostly well-formed frames; some stray bytes, bad lengths, cut-off frames
  task automatic send_random_frame();
    int pick;
    int len;
    int sent;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      push_item(make_item(fmb_pkg::ACT_PAYLOAD, 0), 1'b0, NO_PIN);
    end else if (pick < 14) begin
      len = ($urandom_range(0, 2) == 0) ? 0
          : $urandom_range(fmb_pkg::MAX_PAYLOAD_DEF + 1, 2047);
      push_item(make_item(fmb_pkg::ACT_START, len), 1'b0, NO_PIN);
    end else begin
      if (pick < 70) len = $urandom_range(1, 6);
      else if (pick < 90) len = $urandom_range(7, 40);
      else len = $urandom_range(41, fmb_pkg::MAX_PAYLOAD_DEF);
      sent = len;
      if (len > 40) sent = $urandom_range(0, 12);
      else if ($urandom_range(0, 9) == 0) sent = $urandom_range(0, len - 1);
      push_item(make_item(fmb_pkg::ACT_START, len), 1'b0, NO_PIN);
      repeat (sent) push_item(make_item(fmb_pkg::ACT_PAYLOAD, 0), 1'b0, NO_PIN);
    end
  endtask

  // Receiver stalls: clean, rotating pattern, random, denser pattern
  logic [12:0] stall_pattern = 13'b1_0110_1110_0111;
  logic [9:0]  rx_phase = '0;

  always @(posedge clk) begin
    rx_phase      <= rx_phase + 10'd1;
    stall_pattern <= {stall_pattern[11:0], stall_pattern[12]};
    case (rx_phase[9:8])
      2'd0:    out_ch.ready <= 1'b1;
      2'd1:    out_ch.ready <= stall_pattern[0];
      2'd2:    out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: out_ch.ready <= stall_pattern[0] & stall_pattern[5];
    endcase
  end

  // Compare each frame byte transaction with the oldest expectation
  always @(posedge clk) begin
    frame_out_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        $error("frame_byte: expected none, got %02h (last %0b error %0b)",
               out_ch.frame_byte, out_ch.last, out_ch.error);
        fault_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_ch.frame_byte !== want.frame_byte) begin
          $error("frame_byte: expected %02h, got %02h", want.frame_byte, out_ch.frame_byte);
          fault_count++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_ch.last);
          fault_count++;
        end
        if (out_ch.error !== want.error) begin
          $error("error: expected %0b, got %0b", want.error, out_ch.error);
          fault_count++;
        end
      end
    end
  end

  initial begin
    cfg_profile_t phase_profile [4];
    int   phase_goal;
    logic drained_mid;
    phase_profile = '{PROF_RANDOM, PROF_ZERO, PROF_RANDOM, PROF_ONES};
    drained_mid = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.action         = fmb_pkg::ACT_START;
    in_ch.payload_length = '0;
    in_ch.data_byte      = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = fmb_pkg::REG_DEST_MAC;
    cfg_ch.data          = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIRECTED[r].profile != PROF_KEEP) begin
        settle_idle();
        apply_profile(DIRECTED[r].profile);
      end
      push_item(DIRECTED[r].it, DIRECTED[r].pinned, DIRECTED[r].pin);
    end

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 4; ph++) begin
      settle_idle();
      apply_profile(phase_profile[ph]);
      gap_free = (ph == 2);
      phase_goal = items_sent + RANDOM_ITEMS / 4;
      while (items_sent < phase_goal) begin
        send_random_frame();
        // hold off mid-phase until the framer has emptied out
        if (ph == 1 && !drained_mid && items_sent > phase_goal - RANDOM_ITEMS / 8) begin
          settle_idle();
          drained_mid = 1'b1;
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Run limit
  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
